@@ rtl/atrtm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrtm_pkg
// Shared types and character constants for the modem reply token matcher.
// ----------------------------------------------------------------------------
package atrtm_pkg;

  // Command codes of an input transaction
  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_BYTE   = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  // Reply codes
  typedef enum logic [2:0] {
    KIND_READY   = 3'd0,
    KIND_OK      = 3'd1,
    KIND_ERROR   = 3'd2,
    KIND_IP      = 3'd3,
    KIND_TIMEOUT = 3'd4
  } kind_t;

  // Matcher positions: letters of a token seen so far
  typedef enum logic [3:0] {
    POS_IDLE = 4'd0,
    POS_O    = 4'd1,
    POS_OK   = 4'd2,
    POS_OKR  = 4'd3,
    POS_OR   = 4'd4,
    POS_ORR  = 4'd5,
    POS_I    = 4'd6,
    POS_IP   = 4'd7,
    POS_IPR  = 4'd8,
    POS_D    = 4'd9,
    POS_DY   = 4'd10,
    POS_DYR  = 4'd11
  } pos_t;

  // Characters of the tokens
  localparam logic [7:0] CH_O  = 8'h4F;
  localparam logic [7:0] CH_K  = 8'h4B;
  localparam logic [7:0] CH_R  = 8'h52;
  localparam logic [7:0] CH_I  = 8'h49;
  localparam logic [7:0] CH_P  = 8'h50;
  localparam logic [7:0] CH_D  = 8'h64;
  localparam logic [7:0] CH_Y  = 8'h79;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // Matcher step result
  typedef struct packed {
    pos_t  next_pos;
    logic  done;
    kind_t kind;
  } match_res_t;

endpackage

@@ rtl/atrtm_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrtm_if
// Valid/ready channels: input transactions and reply transactions.
// ----------------------------------------------------------------------------
interface atrtm_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  rx_byte;
  logic [15:0] timeout_ms;

  modport source (output valid, command, rx_byte, timeout_ms, input ready);
  modport sink   (input valid, command, rx_byte, timeout_ms, output ready);
endinterface

interface atrtm_reply_if;
  logic       valid;
  logic       ready;
  logic [2:0] reply_kind;

  modport source (output valid, reply_kind, input ready);
  modport sink   (input valid, reply_kind, output ready);
endinterface

@@ rtl/atrtm_matcher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrtm_matcher
// One step of the token matcher: next position for a received byte, and the
// reply code when the byte completes a token.
// ----------------------------------------------------------------------------
module atrtm_matcher (
  input  atrtm_pkg::pos_t       pos,
  input  logic [7:0]            rx_byte,
  output atrtm_pkg::match_res_t res
);

  atrtm_pkg::pos_t restart;

  // Letters that open a token restart it; anything else goes idle
  always_comb begin
    priority if (rx_byte == atrtm_pkg::CH_O) begin
      restart = atrtm_pkg::POS_O;
    end else if (rx_byte == atrtm_pkg::CH_I) begin
      restart = atrtm_pkg::POS_I;
    end else if (rx_byte == atrtm_pkg::CH_D) begin
      restart = atrtm_pkg::POS_D;
    end else begin
      restart = atrtm_pkg::POS_IDLE;
    end
  end

  // Advance on the expected letter, otherwise restart
  always_comb begin
    res.next_pos = restart;
    res.done     = 1'b0;
    res.kind     = atrtm_pkg::KIND_READY;
    unique case (pos)
      atrtm_pkg::POS_O: begin
        if (rx_byte == atrtm_pkg::CH_K) res.next_pos = atrtm_pkg::POS_OK;
        else if (rx_byte == atrtm_pkg::CH_R) res.next_pos = atrtm_pkg::POS_OR;
      end
      atrtm_pkg::POS_OK: begin
        if (rx_byte == atrtm_pkg::CH_CR) res.next_pos = atrtm_pkg::POS_OKR;
      end
      atrtm_pkg::POS_OR: begin
        if (rx_byte == atrtm_pkg::CH_CR) res.next_pos = atrtm_pkg::POS_ORR;
      end
      atrtm_pkg::POS_I: begin
        if (rx_byte == atrtm_pkg::CH_P) res.next_pos = atrtm_pkg::POS_IP;
      end
      atrtm_pkg::POS_IP: begin
        if (rx_byte == atrtm_pkg::CH_CR) res.next_pos = atrtm_pkg::POS_IPR;
      end
      atrtm_pkg::POS_D: begin
        if (rx_byte == atrtm_pkg::CH_Y) res.next_pos = atrtm_pkg::POS_DY;
      end
      atrtm_pkg::POS_DY: begin
        if (rx_byte == atrtm_pkg::CH_CR) res.next_pos = atrtm_pkg::POS_DYR;
      end
      atrtm_pkg::POS_OKR: begin
        if (rx_byte == atrtm_pkg::CH_LF) begin
          res.done = 1'b1;
          res.kind = atrtm_pkg::KIND_OK;
        end
      end
      atrtm_pkg::POS_ORR: begin
        if (rx_byte == atrtm_pkg::CH_LF) begin
          res.done = 1'b1;
          res.kind = atrtm_pkg::KIND_ERROR;
        end
      end
      atrtm_pkg::POS_IPR: begin
        if (rx_byte == atrtm_pkg::CH_LF) begin
          res.done = 1'b1;
          res.kind = atrtm_pkg::KIND_IP;
        end
      end
      atrtm_pkg::POS_DYR: begin
        if (rx_byte == atrtm_pkg::CH_LF) begin
          res.done = 1'b1;
          res.kind = atrtm_pkg::KIND_READY;
        end
      end
      default: begin
        res.next_pos = restart;
      end
    endcase
  end

endmodule

@@ rtl/at_response_token_matcher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// at_response_token_matcher
// Watches modem bytes for the replies "OK\r\n", "OR\r\n", "IP\r\n" and
// "dy\r\n" and raises a timeout when a millisecond deadline runs out. One
// transaction is accepted every cycle; each passes through an input register
// and the matcher/counter logic into the reply register. The only stall
// comes from the reply register: while it holds an untaken reply the input
// register waits, and the input side stalls once that register is full too.
// Start transactions arm the block and load the deadline; bytes and ticks
// seen while disarmed, and the unused command code, are dropped without a
// reply.
// ----------------------------------------------------------------------------
module at_response_token_matcher (
  input  logic                 clk,
  input  logic                 rst,
  atrtm_item_if.sink           item,
  atrtm_reply_if.source        reply
);

  // Input register
  logic                  s1_valid;
  atrtm_pkg::cmd_t       s1_cmd;
  logic [7:0]            s1_byte;
  logic [15:0]           s1_deadline;

  // Block state
  atrtm_pkg::pos_t       match_position;
  logic                  armed;
  logic [15:0]           time_left;

  // Reply register
  logic                  out_valid;
  atrtm_pkg::kind_t      out_kind;

  // Next values
  atrtm_pkg::pos_t       match_position_next;
  logic                  armed_next;
  logic [15:0]           time_left_next;
  logic                  res_load;
  atrtm_pkg::kind_t      res_kind;
  logic [15:0]           time_dec;

  atrtm_pkg::match_res_t mres;
  logic                  s1_fire;
  logic                  out_free;

  assign out_free   = !out_valid || reply.ready;
  assign s1_fire    = s1_valid && out_free;
  assign item.ready = !s1_valid || out_free;

  assign reply.valid      = out_valid;
  assign reply.reply_kind = out_kind;

  atrtm_matcher u_matcher (
    .pos     (match_position),
    .rx_byte (s1_byte),
    .res     (mres)
  );

  // Saturating countdown
  assign time_dec = (time_left != 16'd0) ? (time_left - 16'd1) : 16'd0;

  // Per-transaction state update
  always_comb begin
    match_position_next = match_position;
    armed_next          = armed;
    time_left_next      = time_left;
    res_load            = 1'b0;
    res_kind            = mres.kind;
    unique case (s1_cmd)
      atrtm_pkg::CMD_START: begin
        armed_next          = 1'b1;
        match_position_next = atrtm_pkg::POS_IDLE;
        time_left_next      = s1_deadline;
      end
      atrtm_pkg::CMD_BYTE: begin
        if (armed) begin
          if (mres.done) begin
            armed_next          = 1'b0;
            match_position_next = atrtm_pkg::POS_IDLE;
            res_load            = 1'b1;
          end else begin
            match_position_next = mres.next_pos;
          end
        end
      end
      atrtm_pkg::CMD_TICK: begin
        if (armed) begin
          time_left_next = time_dec;
          if (time_dec == 16'd0) begin
            armed_next          = 1'b0;
            match_position_next = atrtm_pkg::POS_IDLE;
            res_load            = 1'b1;
            res_kind            = atrtm_pkg::KIND_TIMEOUT;
          end
        end
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
    if (item.valid && item.ready) begin
      s1_cmd      <= atrtm_pkg::cmd_t'(item.command);
      s1_byte     <= item.rx_byte;
      s1_deadline <= item.timeout_ms;
    end
  end

  // State and reply register
  always_ff @(posedge clk) begin
    if (rst) begin
      match_position <= atrtm_pkg::POS_IDLE;
      armed          <= 1'b0;
      time_left      <= 16'd0;
      out_valid      <= 1'b0;
    end else begin
      if (s1_fire) begin
        match_position <= match_position_next;
        armed          <= armed_next;
        time_left      <= time_left_next;
      end
      if (out_free) begin
        out_valid <= s1_fire && res_load;
      end
    end
    if (s1_fire && res_load) begin
      out_kind <= res_kind;
    end
  end

  // Checks
  a_idle_when_disarmed: assert property (@(posedge clk) disable iff (rst)
    !armed |-> match_position == atrtm_pkg::POS_IDLE)
    else $error("matcher not idle while disarmed");

  a_reply_disarms: assert property (@(posedge clk) disable iff (rst)
    s1_fire && res_load |=> !armed && out_valid)
    else $error("reply did not disarm the block");

  a_timeout_from_tick: assert property (@(posedge clk) disable iff (rst)
    s1_fire && res_load && s1_cmd != atrtm_pkg::CMD_TICK
      |=> out_kind != atrtm_pkg::KIND_TIMEOUT)
    else $error("timeout reply from a non-tick transaction");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> s1_valid && out_valid && !reply.ready)
    else $error("input stalled without back-pressure");

endmodule
